// ----- rtl/aabb_pkg.sv -----
`default_nettype none
package aabb_pkg;

	localparam int CoordW = 32;
	localparam int RegW   = 16;
	localparam int CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_ROT_W   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ROT_X   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ROT_Y   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ROT_Z   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SCALE_X = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_SCALE_Y = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SCALE_Z = 3'd6;

	localparam logic signed [RegW-1:0] ROT_ONE   = 16'sd16384;
	localparam logic signed [RegW-1:0] SCALE_ONE = 16'sd256;

	typedef struct packed {
		logic signed [CoordW-1:0] box_min_x;
		logic signed [CoordW-1:0] box_min_y;
		logic signed [CoordW-1:0] box_min_z;
		logic signed [CoordW-1:0] box_max_x;
		logic signed [CoordW-1:0] box_max_y;
		logic signed [CoordW-1:0] box_max_z;
		logic signed [CoordW-1:0] shift_x;
		logic signed [CoordW-1:0] shift_y;
		logic signed [CoordW-1:0] shift_z;
	} box_in_t;

	typedef struct packed {
		logic signed [CoordW-1:0] out_min_x;
		logic signed [CoordW-1:0] out_min_y;
		logic signed [CoordW-1:0] out_min_z;
		logic signed [CoordW-1:0] out_max_x;
		logic signed [CoordW-1:0] out_max_y;
		logic signed [CoordW-1:0] out_max_z;
	} box_out_t;

	// clamp a wide signed value to the signed 32-bit range
	function automatic logic signed [CoordW-1:0] sat32(input logic signed [49:0] v);
		logic signed [49:0] hi;
		logic signed [49:0] lo;
		hi = 50'sd2147483647;
		lo = -50'sd2147483648;
		if (v > hi)
			sat32 = 32'sh7fffffff;
		else if (v < lo)
			sat32 = 32'sh80000000;
		else
			sat32 = v[CoordW-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/aabb_rigid_transform_core.sv -----
`default_nettype none
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_data  (box_in_t: box corners, shift)
// out     | output    | out_valid/ out_ready | out_data (box_out_t: transformed corners)
// cfg     | input     | cfg_we               | cfg_addr, cfg_data
//
// One item a cycle enters and leaves while out_ready holds; the result passes
// through the five pipeline register stages (input, align, multiply, order,
// sum/saturate).
// The matrix is rebuilt from the registers in two clocked steps and is ready
// for items accepted after a write by the time they reach the multipliers.
// Reset restores the identity rotation and unit scale and empties the pipe.
// A stall holds each full stage; empty stages still fill, so no item is lost
// or repeated and bubbles close up behind a stalled output.
module aabb_rigid_transform_core
	import aabb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_addr,
	input  wire logic [RegW-1:0]    cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire box_in_t            in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output box_out_t                out_data
);

	// configuration registers
	logic signed [RegW-1:0] rot_w_q, rot_x_q, rot_y_q, rot_z_q;
	logic signed [RegW-1:0] scale_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_w_q    <= ROT_ONE;
			rot_x_q    <= '0;
			rot_y_q    <= '0;
			rot_z_q    <= '0;
			scale_q[0] <= SCALE_ONE;
			scale_q[1] <= SCALE_ONE;
			scale_q[2] <= SCALE_ONE;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ROT_W:   rot_w_q    <= cfg_data;
				REG_ROT_X:   rot_x_q    <= cfg_data;
				REG_ROT_Y:   rot_y_q    <= cfg_data;
				REG_ROT_Z:   rot_z_q    <= cfg_data;
				REG_SCALE_X: scale_q[0] <= cfg_data;
				REG_SCALE_Y: scale_q[1] <= cfg_data;
				REG_SCALE_Z: scale_q[2] <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	// matrix step one: quaternion products
	logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;

	always_ff @(posedge clk) begin
		xx_q <= rot_x_q * rot_x_q;
		yy_q <= rot_y_q * rot_y_q;
		zz_q <= rot_z_q * rot_z_q;
		xy_q <= rot_x_q * rot_y_q;
		xz_q <= rot_x_q * rot_z_q;
		yz_q <= rot_y_q * rot_z_q;
		wx_q <= rot_w_q * rot_x_q;
		wy_q <= rot_w_q * rot_y_q;
		wz_q <= rot_w_q * rot_z_q;
	end

	// matrix step two: rotation entries (Q.28), scale per column, round to Q.20
	logic signed [33:0] rot_m [3][3];
	logic signed [33:0] one_q28;
	logic signed [31:0] mat_q [3][3];

	always_comb begin
		one_q28 = 34'sd268435456;
		rot_m[0][0] = one_q28 - 34'((34'(yy_q) + 34'(zz_q)) <<< 1);
		rot_m[0][1] = 34'((34'(xy_q) - 34'(wz_q)) <<< 1);
		rot_m[0][2] = 34'((34'(xz_q) + 34'(wy_q)) <<< 1);
		rot_m[1][0] = 34'((34'(xy_q) + 34'(wz_q)) <<< 1);
		rot_m[1][1] = one_q28 - 34'((34'(xx_q) + 34'(zz_q)) <<< 1);
		rot_m[1][2] = 34'((34'(yz_q) - 34'(wx_q)) <<< 1);
		rot_m[2][0] = 34'((34'(xz_q) - 34'(wy_q)) <<< 1);
		rot_m[2][1] = 34'((34'(yz_q) + 34'(wx_q)) <<< 1);
		rot_m[2][2] = one_q28 - 34'((34'(xx_q) + 34'(yy_q)) <<< 1);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				mat_q[i][j] <= sat32((50'(rot_m[i][j]) * 50'(scale_q[j])
					+ 50'sd32768) >>> 16);
			end
		end
	end

	// pipeline handshake: a stage takes a new item when empty or when it moves on
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy2, rdy3, rdy4, rdy5;

	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign in_ready = !v_s1 || rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (rdy2)     v_s2 <= v_s1;
			if (rdy3)     v_s3 <= v_s2;
			if (rdy4)     v_s4 <= v_s3;
			if (rdy5)     v_s5 <= v_s4;
		end
	end

	// stage 1 and 2: hold the item while the matrix settles
	box_in_t box_s1, box_s2;

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) box_s1 <= in_data;
		if (rdy2 && v_s1)         box_s2 <= box_s1;
	end

	logic signed [31:0] lo_c [3];
	logic signed [31:0] hi_c [3];
	logic signed [31:0] pos_c [3];

	always_comb begin
		lo_c[0]  = box_s2.box_min_x;
		lo_c[1]  = box_s2.box_min_y;
		lo_c[2]  = box_s2.box_min_z;
		hi_c[0]  = box_s2.box_max_x;
		hi_c[1]  = box_s2.box_max_y;
		hi_c[2]  = box_s2.box_max_z;
		pos_c[0] = box_s2.shift_x;
		pos_c[1] = box_s2.shift_y;
		pos_c[2] = box_s2.shift_z;
	end

	// stage 3: eighteen products, rounded to Q.16
	logic signed [43:0] ta_s3 [3][3];
	logic signed [43:0] tb_s3 [3][3];
	logic signed [31:0] pos_s3 [3];

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			for (int i = 0; i < 3; i++) begin
				pos_s3[i] <= pos_c[i];
				for (int j = 0; j < 3; j++) begin
					ta_s3[i][j] <= 44'((64'(mat_q[i][j]) * 64'(lo_c[j])
						+ 64'sd524288) >>> 20);
					tb_s3[i][j] <= 44'((64'(mat_q[i][j]) * 64'(hi_c[j])
						+ 64'sd524288) >>> 20);
				end
			end
		end
	end

	// stage 4: order each pair of terms
	logic signed [43:0] tlo_s4 [3][3];
	logic signed [43:0] thi_s4 [3][3];
	logic signed [31:0] pos_s4 [3];

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			for (int i = 0; i < 3; i++) begin
				pos_s4[i] <= pos_s3[i];
				for (int j = 0; j < 3; j++) begin
					if (ta_s3[i][j] < tb_s3[i][j]) begin
						tlo_s4[i][j] <= ta_s3[i][j];
						thi_s4[i][j] <= tb_s3[i][j];
					end else begin
						tlo_s4[i][j] <= tb_s3[i][j];
						thi_s4[i][j] <= ta_s3[i][j];
					end
				end
			end
		end
	end

	// stage 5: sum with the shift and saturate into the output register
	logic signed [49:0] sum_lo [3];
	logic signed [49:0] sum_hi [3];
	box_out_t res_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_lo[i] = 50'(pos_s4[i]) + 50'(tlo_s4[i][0]) + 50'(tlo_s4[i][1])
				+ 50'(tlo_s4[i][2]);
			sum_hi[i] = 50'(pos_s4[i]) + 50'(thi_s4[i][0]) + 50'(thi_s4[i][1])
				+ 50'(thi_s4[i][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			res_s5.out_min_x <= sat32(sum_lo[0]);
			res_s5.out_min_y <= sat32(sum_lo[1]);
			res_s5.out_min_z <= sat32(sum_lo[2]);
			res_s5.out_max_x <= sat32(sum_hi[0]);
			res_s5.out_max_y <= sat32(sum_hi[1]);
			res_s5.out_max_z <= sat32(sum_hi[2]);
		end
	end

	assign out_valid = v_s5;
	assign out_data  = res_s5;

endmodule
`default_nettype wire
